// ----- src/kvpt_pkg.sv -----
// Shared types and constants for the key/value parameter tokenizer.
package kvpt_pkg;

  localparam int MAX_TEXT_LEN = 4096;
  localparam int POS_W = $clog2(MAX_TEXT_LEN);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_LEN - 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] SEP_RESET = 8'h3D;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_KEY     = 3'd1,
    PH_SEPSEEK = 3'd2,
    PH_VALSEEK = 3'd3,
    PH_VAL     = 3'd4,
    PH_QVAL    = 3'd5
  } phase_t;

  typedef struct packed {
    logic nul;
    logic ws;
    logic nl;
    logic sep;
    logic semi;
    logic quote;
  } cls_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    cls_t             cls;
  } item_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

endpackage

// ----- src/kvpt_front.sv -----
// Front end: separator register, character classification and position tagging.
module kvpt_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               separator_char,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  input  logic                     q_full,
  output logic                     q_push,
  output kvpt_pkg::item_t          q_item
);

  logic [7:0]                 sep;
  logic [kvpt_pkg::POS_W-1:0] position;
  logic [kvpt_pkg::POS_W-1:0] position_next;
  kvpt_pkg::cls_t             cls;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    cls.nul   = (char_code == kvpt_pkg::CH_NUL);
    cls.nl    = (char_code == kvpt_pkg::CH_CR) || (char_code == kvpt_pkg::CH_LF);
    cls.ws    = cls.nl || (char_code == kvpt_pkg::CH_SPACE) ||
                (char_code == kvpt_pkg::CH_TAB);
    cls.sep   = (char_code == sep);
    cls.semi  = (char_code == kvpt_pkg::CH_SEMI);
    cls.quote = (char_code == kvpt_pkg::CH_QUOTE);
  end

  assign q_item.pos = position;
  assign q_item.cls = cls;

  assign position_next = cls.nul ? '0 : kvpt_pkg::sat_inc(position);

  always_ff @(posedge clk) begin
    if (rst) begin
      sep      <= kvpt_pkg::SEP_RESET;
      position <= '0;
    end else begin
      if (cfg_valid) begin
        sep <= separator_char;
      end
      if (q_push) begin
        position <= position_next;
      end
    end
  end

endmodule

// ----- src/kvpt_queue.sv -----
// Small FIFO of classified characters between front and back.
module kvpt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kvpt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output kvpt_pkg::item_t pop_item
);

  kvpt_pkg::item_t             entries [kvpt_pkg::Q_DEPTH];
  logic [kvpt_pkg::Q_AW-1:0]   wr_ptr;
  logic [kvpt_pkg::Q_AW-1:0]   rd_ptr;
  logic [kvpt_pkg::Q_AW:0]     count;

  assign full      = (count == (kvpt_pkg::Q_AW+1)'(kvpt_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + kvpt_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + kvpt_pkg::Q_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (kvpt_pkg::Q_AW+1)'(1);
        2'b01:   count <= count - (kvpt_pkg::Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/kvpt_back.sv -----
// Back end: parse state machine and registered result output.
module kvpt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  kvpt_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kvpt_pkg::POS_W-1:0]  key_start,
  output logic [kvpt_pkg::POS_W-1:0]  key_end,
  output logic                        has_value,
  output logic [kvpt_pkg::POS_W-1:0]  value_start,
  output logic [kvpt_pkg::POS_W-1:0]  value_end
);

  kvpt_pkg::phase_t           phase;
  kvpt_pkg::phase_t           phase_next;
  logic [kvpt_pkg::POS_W-1:0] ks, ks_next;
  logic [kvpt_pkg::POS_W-1:0] ke, ke_next;
  logic [kvpt_pkg::POS_W-1:0] vs, vs_next;
  logic                       emit;
  logic [kvpt_pkg::POS_W-1:0] e_ks, e_ke, e_vs, e_ve;
  logic                       e_hv;
  kvpt_pkg::cls_t             c;
  logic [kvpt_pkg::POS_W-1:0] pos;

  assign c     = q_item.cls;
  assign pos   = q_item.pos;
  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    phase_next = phase;
    if (q_pop) begin
      if (c.nul) begin
        phase_next = kvpt_pkg::PH_IDLE;
      end else begin
        unique case (phase)
          kvpt_pkg::PH_KEY: begin
            if (c.ws) begin
              phase_next = kvpt_pkg::PH_SEPSEEK;
            end else if (c.sep) begin
              phase_next = kvpt_pkg::PH_VALSEEK;
            end else if (c.semi) begin
              phase_next = kvpt_pkg::PH_IDLE;
            end
          end
          kvpt_pkg::PH_SEPSEEK: begin
            if (c.sep) begin
              phase_next = kvpt_pkg::PH_VALSEEK;
            end else if (c.semi) begin
              phase_next = kvpt_pkg::PH_IDLE;
            end else if (!c.ws) begin
              phase_next = kvpt_pkg::PH_KEY;
            end
          end
          kvpt_pkg::PH_VALSEEK: begin
            if (!c.ws) begin
              phase_next = c.quote ? kvpt_pkg::PH_QVAL : kvpt_pkg::PH_VAL;
            end else if (c.nl) begin
              phase_next = kvpt_pkg::PH_IDLE;
            end
          end
          kvpt_pkg::PH_VAL: begin
            if (c.ws || c.semi) begin
              phase_next = kvpt_pkg::PH_IDLE;
            end
          end
          kvpt_pkg::PH_QVAL: begin
            if (c.quote) begin
              phase_next = kvpt_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_next = (!c.ws && !c.semi) ? kvpt_pkg::PH_KEY : kvpt_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    ks_next = ks;
    ke_next = ke;
    vs_next = vs;
    emit    = 1'b0;
    e_ks    = ks;
    e_ke    = ke;
    e_hv    = 1'b1;
    e_vs    = vs;
    e_ve    = pos;
    if (q_pop) begin
      if (c.nul) begin
        emit = (phase == kvpt_pkg::PH_VAL) || (phase == kvpt_pkg::PH_QVAL);
      end else begin
        unique case (phase)
          kvpt_pkg::PH_KEY: begin
            if (c.ws || c.sep || c.semi) begin
              ke_next = pos;
            end
            if (!c.ws && !c.sep && c.semi) begin
              emit = 1'b1;
              e_ke = pos;
              e_hv = 1'b0;
              e_vs = '0;
              e_ve = '0;
            end
          end
          kvpt_pkg::PH_SEPSEEK: begin
            if (!c.sep && c.semi) begin
              emit = 1'b1;
              e_hv = 1'b0;
              e_vs = '0;
              e_ve = '0;
            end else if (!c.sep && !c.ws) begin
              ks_next = pos;
            end
          end
          kvpt_pkg::PH_VALSEEK: begin
            if (!c.ws) begin
              vs_next = c.quote ? kvpt_pkg::sat_inc(pos) : pos;
            end else if (c.nl) begin
              emit = 1'b1;
              e_vs = pos;
            end
          end
          kvpt_pkg::PH_VAL: begin
            emit = c.ws || c.semi;
          end
          kvpt_pkg::PH_QVAL: begin
            emit = c.quote;
          end
          default: begin
            if (!c.ws && !c.semi) begin
              ks_next = pos;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= kvpt_pkg::PH_IDLE;
      ks        <= '0;
      ke        <= '0;
      vs        <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      ks    <= ks_next;
      ke    <= ke_next;
      vs    <= vs_next;
      if (q_pop) begin
        out_valid <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      key_start   <= e_ks;
      key_end     <= e_ke;
      has_value   <= e_hv;
      value_start <= e_vs;
      value_end   <= e_ve;
    end
  end

endmodule

// ----- src/key_value_param_tokenizer_top.sv -----
// Top level of the key/value parameter tokenizer.
// A character reaches the outputs through a queue entry and then the registered result.
// Throughput: one character per cycle unless stalled; 4-entry queue decouples classify/parse.
// The back end advances whenever the result register is empty or being taken.
// Reset (rst, synchronous): parser idle, position zero, queue empty, separator '='.
module key_value_param_tokenizer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  separator_char,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kvpt_pkg::POS_W-1:0]  key_start,
  output logic [kvpt_pkg::POS_W-1:0]  key_end,
  output logic                        has_value,
  output logic [kvpt_pkg::POS_W-1:0]  value_start,
  output logic [kvpt_pkg::POS_W-1:0]  value_end
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  kvpt_pkg::item_t push_item;
  kvpt_pkg::item_t pop_item;

  kvpt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .separator_char (separator_char),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  kvpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  kvpt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .key_start   (key_start),
    .key_end     (key_end),
    .has_value   (has_value),
    .value_start (value_start),
    .value_end   (value_end)
  );

endmodule

// ----- src/kvpt_checker.sv -----
// Port-level assertions for the tokenizer top level, bound onto it.
module kvpt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [7:0]                  separator_char,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [7:0]                  char_code,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [kvpt_pkg::POS_W-1:0]  key_start,
  input logic [kvpt_pkg::POS_W-1:0]  key_end,
  input logic                        has_value,
  input logic [kvpt_pkg::POS_W-1:0]  value_start,
  input logic [kvpt_pkg::POS_W-1:0]  value_end
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_start) && $stable(value_end))
    else $error("stalled result dropped or changed");

  a_bare_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_value |-> value_start == '0 && value_end == '0)
    else $error("bare key with nonzero value bounds");

  a_value_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_value |-> value_start <= value_end && key_end <= value_start)
    else $error("value bounds out of order");

  a_key_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_start <= key_end)
    else $error("key bounds out of order");

endmodule

bind key_value_param_tokenizer_top kvpt_checker u_kvpt_checker (.*);
